// ----- hdl/prq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prq_pkg
// Shared types and constants for the pitch ratio quantizer: item layouts,
// request codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
package prq_pkg;

  localparam int NOTE_W   = 24;
  localparam int ENTRY_W  = 21;
  localparam int EIDX_W   = 4;
  localparam int CFG_W    = 5;
  localparam int OCT_W    = 5;
  localparam int Q_DEPTH  = 4;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUANT = 1'b1;

  typedef struct packed {
    logic               req_type;
    logic [EIDX_W-1:0]  entry_index;
    logic [ENTRY_W-1:0] entry_ratio;
    logic [NOTE_W-1:0]  note_ratio;
  } prq_in_t;

  typedef struct packed {
    logic [NOTE_W-1:0] quantized_ratio;
    logic              saturated;
  } prq_out_t;

endpackage : prq_pkg
`default_nettype wire

// ----- hdl/prq_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prq_queue
// Short first-word-fall-through queue of classified items between the
// front end and the execution unit.
// ----------------------------------------------------------------------------
module prq_queue
  import prq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire prq_in_t push_item,
  output logic         full,
  output logic         valid,
  output prq_in_t      head,
  input  wire logic    pop
);

  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  prq_in_t            mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign full    = (count_r == CNT_W'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule : prq_queue
`default_nettype wire

// ----- hdl/prq_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prq_front
// Front end: holds the scale length register, accepts input items and
// forwards quantize items and in-range table writes to the work queue.
// ----------------------------------------------------------------------------
module prq_front
  import prq_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire prq_in_t          in_item,
  output logic                  in_full,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  q_push,
  output prq_in_t               q_item,
  input  wire logic             q_full,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] len
);

  localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             idx_ok;

  // Writes beyond the table are dropped here and never reach the back end.
  assign idx_ok  = (32'(in_item.entry_index) < TABLE_DEPTH);
  assign in_full = q_full;
  assign q_push  = in_push && !q_full && ((in_item.req_type == REQ_QUANT) || idx_ok);
  assign q_item  = in_item;
  assign len     = len_r;

  always_comb begin
    len_nxt = len_r;
    if (cfg_we) begin
      if (cfg_wdata == '0) begin
        len_nxt = LEN_W'(1);
      end else if (32'(cfg_wdata) > TABLE_DEPTH) begin
        len_nxt = LEN_W'(TABLE_DEPTH);
      end else begin
        len_nxt = LEN_W'(32'(cfg_wdata));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_W'(1);
    end else begin
      len_r <= len_nxt;
    end
  end

endmodule : prq_front
`default_nettype wire

// ----- hdl/prq_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// prq_back
// Execution unit: owns the scale table, finds the octave, scans the table
// for the bracketing entries, picks the nearer one by cross-multiplying and
// restores the octave into the output register, saturating on overflow.
// ----------------------------------------------------------------------------
module prq_back
  import prq_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire prq_in_t q_head,
  output logic         q_pop,
  input  wire logic [$clog2(TABLE_DEPTH+1)-1:0] len,
  output logic         out_empty,
  input  wire logic    out_pop,
  output prq_out_t     out_item
);

  localparam int LEN_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = $clog2(TABLE_DEPTH);
  localparam int TWO_W  = FRAC_BITS + 2;
  localparam int VAL_W  = (ENTRY_W > TWO_W) ? ENTRY_W : TWO_W;
  localparam int TH_W   = NOTE_W + 2;
  localparam int PROD_W = VAL_W + ENTRY_W;
  localparam int SQ_W   = 2 * NOTE_W;
  localparam int CMP_W  = (PROD_W > SQ_W) ? PROD_W : SQ_W;
  localparam int RES_W  = VAL_W + NOTE_W;

  localparam logic [VAL_W-1:0] TWO_VAL = VAL_W'(1) << (FRAC_BITS + 1);
  localparam logic [TH_W-1:0]  TWO_TH  = TH_W'(1) << (FRAC_BITS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LAST = 8'b0000_0010,
    S_OCT  = 8'b0000_0100,
    S_SCAN = 8'b0000_1000,
    S_MULA = 8'b0001_0000,
    S_MULB = 8'b0010_0000,
    S_CMP  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } prq_state_t;

  prq_state_t         state_r, state_nxt;
  logic [ENTRY_W-1:0] mem_r [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [IDX_W-1:0]   rd_addr;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;

  logic [NOTE_W-1:0]  note_r, note_nxt;
  logic [NOTE_W-1:0]  note_hi_r, note_hi_nxt;
  logic               lo_nz_r, lo_nz_nxt;
  logic               reduce_r, reduce_nxt;
  logic [OCT_W-1:0]   oct_r, oct_nxt;
  logic [TH_W-1:0]    thresh_r, thresh_nxt;
  logic [LEN_W-1:0]   j_r, j_nxt, j_inc, len_m1;
  logic [ENTRY_W-1:0] below_r, below_nxt;
  logic [VAL_W-1:0]   above_r, above_nxt;
  logic [PROD_W-1:0]  lhs_r, lhs_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [VAL_W-1:0]   pick_r, pick_nxt;
  logic               out_valid_r, out_valid_nxt;
  prq_out_t           out_item_r, out_item_nxt;

  logic               take;
  logic               slot_free;
  logic [RES_W-1:0]   res;

  assign out_empty = !out_valid_r;
  assign out_item  = out_item_r;
  assign slot_free = !out_valid_r || out_pop;
  assign len_m1    = len - LEN_W'(1);
  assign j_inc     = j_r + LEN_W'(1);
  assign res       = RES_W'(pick_r) << oct_r;

  // The first table entry is always taken as the lower bracket; later ones
  // are taken while the note still lies strictly above the entry.
  assign take = (j_r == '0) ||
                (note_hi_r > NOTE_W'(rd_data_r)) ||
                ((note_hi_r == NOTE_W'(rd_data_r)) && lo_nz_r);

  always_comb begin
    state_nxt     = state_r;
    note_nxt      = note_r;
    note_hi_nxt   = note_hi_r;
    lo_nz_nxt     = lo_nz_r;
    reduce_nxt    = reduce_r;
    oct_nxt       = oct_r;
    thresh_nxt    = thresh_r;
    j_nxt         = j_r;
    below_nxt     = below_r;
    above_nxt     = above_r;
    lhs_nxt       = lhs_r;
    sq_nxt        = sq_r;
    pick_nxt      = pick_r;
    out_valid_nxt = out_valid_r;
    out_item_nxt  = out_item_r;
    q_pop         = 1'b0;
    wr_en         = 1'b0;
    wr_addr       = IDX_W'(32'(q_head.entry_index));
    rd_addr       = len_m1[IDX_W-1:0];

    if (out_pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_head.req_type == REQ_WRITE) begin
            wr_en = 1'b1;
          end else begin
            note_nxt  = q_head.note_ratio;
            state_nxt = S_LAST;
          end
        end
      end
      S_LAST: begin
        reduce_nxt = (VAL_W'(rd_data_r) < TWO_VAL);
        oct_nxt    = '0;
        thresh_nxt = TWO_TH;
        state_nxt  = S_OCT;
      end
      S_OCT: begin
        rd_addr = '0;
        if (reduce_r && (TH_W'(note_r) > thresh_r)) begin
          oct_nxt    = oct_r + OCT_W'(1);
          thresh_nxt = thresh_r << 1;
        end else begin
          note_hi_nxt = note_r >> oct_r;
          lo_nz_nxt   = |(note_r & ~({NOTE_W{1'b1}} << oct_r));
          j_nxt       = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_addr = j_inc[IDX_W-1:0];
        if (take) begin
          below_nxt = rd_data_r;
          j_nxt     = j_inc;
          if (j_inc == len) begin
            above_nxt = TWO_VAL;
            state_nxt = S_MULA;
          end
        end else begin
          above_nxt = VAL_W'(rd_data_r);
          state_nxt = S_MULA;
        end
      end
      S_MULA: begin
        lhs_nxt   = PROD_W'(above_r * below_r);
        state_nxt = S_MULB;
      end
      S_MULB: begin
        sq_nxt    = SQ_W'(note_r * note_r);
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Lower entry wins only when it is strictly nearer; ties go up.
        if (CMP_W'(lhs_r) > CMP_W'(sq_r >> {oct_r, 1'b0})) begin
          pick_nxt = VAL_W'(below_r);
        end else begin
          pick_nxt = above_r;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          if (|res[RES_W-1:NOTE_W]) begin
            out_item_nxt.quantized_ratio = {NOTE_W{1'b1}};
            out_item_nxt.saturated       = 1'b1;
          end else begin
            out_item_nxt.quantized_ratio = res[NOTE_W-1:0];
            out_item_nxt.saturated       = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    note_r     <= note_nxt;
    note_hi_r  <= note_hi_nxt;
    lo_nz_r    <= lo_nz_nxt;
    reduce_r   <= reduce_nxt;
    oct_r      <= oct_nxt;
    thresh_r   <= thresh_nxt;
    j_r        <= j_nxt;
    below_r    <= below_nxt;
    above_r    <= above_nxt;
    lhs_r      <= lhs_nxt;
    sq_r       <= sq_nxt;
    pick_r     <= pick_nxt;
    out_item_r <= out_item_nxt;
  end

  // Scale table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= q_head.entry_ratio;
    end
    rd_data_r <= mem_r[rd_addr];
  end

endmodule : prq_back
`default_nettype wire

// ----- hdl/pitch_ratio_quantizer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pitch_ratio_quantizer
// Snaps a UQ8.16 pitch ratio to the nearest degree of a loaded scale table.
//
// Input items enter through in_push/in_full. A write item stores one table
// entry and gives no result; a quantize item gives exactly one result on
// out_item, shown while out_empty is low and taken with out_pop. cfg_we and
// cfg_wdata set the number of table entries in use; they are to be written
// only while the block is idle, which the block itself does not enforce.
// Entries are to be read back only after being written; the block does not
// enforce this either. Items pass through a four-deep queue, so the input
// stays open while the execution unit is busy or a result waits. A table
// write is handled in the idle state of the execution unit. A quantize item
// goes from queue head to result register through S_LAST, S_OCT, S_SCAN,
// S_MULA, S_MULB, S_CMP and S_OUT: the octave search steps once per octave
// and the table scan reads one entry per cycle from a single read port. A
// stalled result holds the execution unit; the queue keeps filling until
// full. Reset empties the queue and the result register and sets the
// length to one entry.
// ----------------------------------------------------------------------------
module pitch_ratio_quantizer
  import prq_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire prq_in_t          in_item,
  output logic                  in_full,
  output logic                  out_empty,
  input  wire logic             out_pop,
  output prq_out_t              out_item,
  input  wire logic             cfg_we,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int LEN_W = $clog2(TABLE_DEPTH + 1);

  logic             q_push;
  prq_in_t          q_item;
  logic             q_full;
  logic             q_valid;
  prq_in_t          q_head;
  logic             q_pop;
  logic [LEN_W-1:0] len;

  prq_front #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_item   (in_item),
    .in_full   (in_full),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full),
    .len       (len)
  );

  prq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head),
    .pop       (q_pop)
  );

  prq_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .len       (len),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_item  (out_item)
  );

endmodule : pitch_ratio_quantizer
`default_nettype wire

// ----- tb/sv/pitch_ratio_quantizer_test.sv -----
// ----------------------------------------------------------------------------
// pitch_ratio_quantizer_test
// Self-checking bench for the pitch ratio quantizer. It loads scale tables,
// sends notes and compares every result with an in-bench prediction kept in
// step with the accepted items, under three different idling patterns.
// ----------------------------------------------------------------------------
module pitch_ratio_quantizer_test;
  import prq_pkg::*;

  localparam int TBL_DEPTH = TABLE_DEPTH_DEF;
  localparam int FRAC = FRAC_BITS_DEF;
  localparam longint unsigned TWO_RATIO = 64'd2 << FRAC;
  localparam int ONE_INT = 1 << FRAC;
  localparam int TWO_INT = 2 << FRAC;
  localparam int ENTRY_MAX = (1 << ENTRY_W) - 1;
  localparam int NOTE_MAX = (1 << NOTE_W) - 1;
  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 100;
  localparam int ITEMS_PER_PHASE = 560;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst_n;
  logic in_push;
  prq_in_t in_item;
  logic in_full;
  logic out_empty;
  logic out_pop;
  prq_out_t out_item;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // Prediction state, updated at the edge where an item is accepted.
  logic [ENTRY_W-1:0] table_model [TBL_DEPTH];
  logic [CFG_W-1:0] length_model;
  prq_out_t expected_quant_q[$];

  // Table contents the stimulus intends to load; used to aim notes.
  logic [ENTRY_W-1:0] scale_plan [TBL_DEPTH];

  int send_gap_pct;
  int pop_gap_pct;
  int items_sent;
  int mismatches;
  int stall_cycles = 0;

  pitch_ratio_quantizer #(
    .TABLE_DEPTH(TBL_DEPTH),
    .FRAC_BITS  (FRAC)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_item  (in_item),
    .in_full  (in_full),
    .out_empty(out_empty),
    .out_pop  (out_pop),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic prq_out_t quantize_note(logic [NOTE_W-1:0] note);
    longint unsigned n;
    longint unsigned below;
    longint unsigned above;
    longint unsigned pick;
    longint unsigned res;
    int len;
    int j;
    int oct;
    prq_out_t r;
    n = note;
    len = length_model;
    if (len < 1) len = 1;
    if (len > TBL_DEPTH) len = TBL_DEPTH;
    oct = 0;
    // The note is folded down by octaves only when the table stops short of 2.0.
    if (64'(table_model[len-1]) < TWO_RATIO) begin
      while (n > (TWO_RATIO << oct)) oct++;
    end
    j = 1;
    while (j < len && n > (64'(table_model[j]) << oct)) j++;
    below = table_model[j-1];
    above = (j == len) ? TWO_RATIO : 64'(table_model[j]);
    // Cross-multiplied nearness test at the folded octave; a tie goes up.
    pick = (above * below > ((n * n) >> (2 * oct))) ? below : above;
    res = pick << oct;
    r.saturated = (res > 64'(NOTE_MAX));
    r.quantized_ratio = r.saturated ? '1 : NOTE_W'(res);
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      length_model = 5'd1;
      for (int i = 0; i < TBL_DEPTH; i++) table_model[i] = '0;
    end else begin
      if (cfg_we) length_model = cfg_wdata;
      if (in_push && !in_full) begin
        if (in_item.req_type == REQ_WRITE) begin
          table_model[in_item.entry_index] = in_item.entry_ratio;
        end else begin
          expected_quant_q.push_back(quantize_note(in_item.note_ratio));
        end
      end
    end
  end

  task automatic flag_mismatch(string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin
    prq_out_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_quant_q.size() == 0) begin
        flag_mismatch($sformatf("result ratio %h sat %b with nothing expected",
                                out_item.quantized_ratio, out_item.saturated));
      end else begin
        want = expected_quant_q.pop_front();
        if (out_item.quantized_ratio !== want.quantized_ratio) begin
          flag_mismatch($sformatf("quantized_ratio %h, expected %h",
                                  out_item.quantized_ratio, want.quantized_ratio));
        end
        if (out_item.saturated !== want.saturated) begin
          flag_mismatch($sformatf("saturated %b, expected %b (ratio %h)",
                                  out_item.saturated, want.saturated, want.quantized_ratio));
        end
      end
    end
  end

  always @(negedge clk) begin
    out_pop <= rst_n && ($urandom_range(0, 99) >= pop_gap_pct);
  end

  // Ends the run when nothing at all has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || cfg_we) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("pitch_ratio_quantizer test failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Returns at the rising edge where the item is accepted; in_push is left
  // high so that a following item can go out without a gap.
  task automatic send_item(prq_in_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      in_push <= 1'b0;
      @(negedge clk);
    end
    in_push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_full) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_entry(int idx, logic [ENTRY_W-1:0] ratio);
    prq_in_t it;
    it.req_type = REQ_WRITE;
    it.entry_index = idx[EIDX_W-1:0];
    it.entry_ratio = ratio;
    it.note_ratio = NOTE_W'($urandom_range(0, NOTE_MAX));
    send_item(it);
  endtask

  task automatic quantize(logic [NOTE_W-1:0] note);
    prq_in_t it;
    it.req_type = REQ_QUANT;
    it.entry_index = EIDX_W'($urandom());
    it.entry_ratio = ENTRY_W'($urandom_range(0, ENTRY_MAX));
    it.note_ratio = note;
    send_item(it);
  endtask

  // Write items leave no result behind, so a settling pause follows the drain.
  task automatic wait_until_idle();
    @(negedge clk);
    in_push <= 1'b0;
    while (expected_quant_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_scale_length(int len);
    wait_until_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= CFG_W'(len);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly ascending tables below 2.0 as real scales have, some ascending
  // over the full entry range, and some unsorted noise.
  task automatic plan_scale(int eff_len);
    int kind;
    int lo;
    int hi;
    logic [ENTRY_W-1:0] t;
    kind = $urandom_range(0, 99);
    lo = ($urandom_range(0, 1) == 1) ? ONE_INT : 0;
    hi = (kind < 60) ? TWO_INT - 1 : ENTRY_MAX;
    for (int i = 0; i < eff_len; i++) scale_plan[i] = ENTRY_W'($urandom_range(lo, hi));
    if (kind < 60 && $urandom_range(0, 1) == 1) scale_plan[0] = ENTRY_W'(ONE_INT);
    if (kind < 85) begin
      for (int i = 0; i < eff_len; i++) begin
        for (int j = i + 1; j < eff_len; j++) begin
          if (scale_plan[j] < scale_plan[i]) begin
            t = scale_plan[i];
            scale_plan[i] = scale_plan[j];
            scale_plan[j] = t;
          end
        end
      end
    end
  endtask

  function automatic logic [NOTE_W-1:0] pick_note(int eff_len);
    longint v;
    longint lo;
    longint hi;
    int k;
    int oct;
    k = $urandom_range(0, eff_len - 1);
    oct = $urandom_range(0, 7);
    case ($urandom_range(0, 4))
      0: v = $urandom_range(0, NOTE_MAX);
      1: v = $urandom_range(0, 3 * ONE_INT);
      2: v = (longint'(scale_plan[k]) << oct) + longint'($urandom_range(0, 6)) - 3;
      3: begin
        // Close to the geometric mean of two neighbors, where ties live.
        lo = scale_plan[k];
        hi = (k + 1 < eff_len) ? longint'(scale_plan[k+1]) : longint'(TWO_RATIO);
        v = longint'($sqrt(real'(lo) * real'(hi)));
        v = (v << oct) + longint'($urandom_range(0, 2)) - 1;
      end
      default: begin
        case ($urandom_range(0, 3))
          0: v = 0;
          1: v = NOTE_MAX;
          2: v = longint'(TWO_RATIO) << oct;
          default: v = (longint'(TWO_RATIO) << oct) + 1;
        endcase
      end
    endcase
    if (v < 0) v = 0;
    if (v > NOTE_MAX) v = NOTE_MAX;
    return NOTE_W'(v);
  endfunction

  task automatic run_scale_block();
    int cfg_val;
    int eff_len;
    int n_notes;
    int idx;
    logic [ENTRY_W-1:0] ratio;
    case ($urandom_range(0, 9))
      0: cfg_val = 0;
      1: cfg_val = (1 << CFG_W) - 1;
      2: cfg_val = 1;
      3: cfg_val = TBL_DEPTH;
      default: cfg_val = $urandom_range(2, TBL_DEPTH - 1);
    endcase
    eff_len = (cfg_val < 1) ? 1 : (cfg_val > TBL_DEPTH) ? TBL_DEPTH : cfg_val;
    set_scale_length(cfg_val);
    plan_scale(eff_len);
    for (int i = 0; i < eff_len; i++) write_entry(i, scale_plan[i]);
    // Entries past the active length never affect a result, so any value may go there.
    if ($urandom_range(0, 3) == 0) begin
      for (int i = eff_len; i < TBL_DEPTH; i++) begin
        ratio = ENTRY_W'($urandom_range(0, ENTRY_MAX));
        scale_plan[i] = ratio;
        write_entry(i, ratio);
      end
    end
    n_notes = $urandom_range(10, 40);
    for (int i = 0; i < n_notes; i++) begin
      if ($urandom_range(0, 19) == 0) begin
        idx = $urandom_range(0, TBL_DEPTH - 1);
        ratio = ENTRY_W'($urandom_range(0, ENTRY_MAX));
        scale_plan[idx] = ratio;
        write_entry(idx, ratio);
      end
      quantize(pick_note(eff_len));
    end
  endtask

  // Reset leaves one entry in use; the largest note must saturate.
  task automatic test_reset_length();
    write_entry(0, ENTRY_W'(ONE_INT));
    quantize('0);
    quantize(NOTE_W'(ONE_INT / 2));
    quantize(NOTE_W'(ONE_INT + ONE_INT / 2));
    quantize(NOTE_W'(NOTE_MAX));
  endtask

  task automatic test_tie_and_zero();
    set_scale_length(2);
    write_entry(0, ENTRY_W'(ONE_INT));
    write_entry(1, ENTRY_W'(4 * ONE_INT));
    quantize(NOTE_W'(TWO_INT));
    quantize('0);
    write_entry(0, '0);
    quantize(NOTE_W'(ONE_INT));
    quantize('0);
  endtask

  task automatic test_length_extremes();
    set_scale_length(0);
    quantize(NOTE_W'(24'h123456));
    write_entry(1, ENTRY_W'(ENTRY_MAX));
    set_scale_length(2);
    quantize(NOTE_W'(NOTE_MAX));
    quantize(NOTE_W'(ENTRY_MAX));
    quantize(NOTE_W'(ENTRY_MAX + 1));
  endtask

  task automatic test_random_phase(int send_pct, int pop_pct);
    int phase_end;
    send_gap_pct = send_pct;
    pop_gap_pct = pop_pct;
    phase_end = items_sent + ITEMS_PER_PHASE;
    while (items_sent < phase_end) run_scale_block();
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_item = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    send_gap_pct = 7;
    pop_gap_pct = 72;
    items_sent = 0;
    mismatches = 0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_length();
    test_tie_and_zero();
    test_length_extremes();
    test_random_phase(7, 72);
    test_random_phase(72, 7);
    test_random_phase(0, 0);

    wait_until_idle();
    if (mismatches == 0 && expected_quant_q.size() == 0) begin
      $display("pitch_ratio_quantizer test passed");
    end else begin
      $display("pitch_ratio_quantizer test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/prq_pkg.sv
hdl/prq_queue.sv
hdl/prq_front.sv
hdl/prq_back.sv
hdl/pitch_ratio_quantizer.sv
tb/sv/pitch_ratio_quantizer_test.sv
